// ----- hdl/pks_pkg.sv -----
// Package for the patch keypoint selector: sizes, register indexes, word
// structs, the column store entry and the sequencer states.
// No dependencies; pks_div and the top level in hdl/ import it.
package pks_pkg;

  // Design limits
  localparam int MAX_PATCH_COLS = 64;
  localparam int PATCH_ROWS_MAX = 64;
  localparam int COORD_BITS     = 12;

  // Clamped frame size holds up to 2^COORD_BITS.
  localparam int WB    = COORD_BITS + 1;
  localparam int COLQ  = (MAX_PATCH_COLS > 1) ? $clog2(MAX_PATCH_COLS) : 1;
  localparam int ROWQ  = (PATCH_ROWS_MAX > 1) ? $clog2(PATCH_ROWS_MAX) : 1;
  // Quotient bits of the patch search; a clamped patch count needs one more.
  localparam int QBITS = (COLQ > ROWQ) ? COLQ : ROWQ;
  localparam int PB    = QBITS + 1;
  // Dividend of the patch search stays below frame size times patch count.
  localparam int DVB   = COORD_BITS + QBITS;
  // Products of a coordinate or patch bound with a size or count.
  localparam int PRODB = WB + PB;

  localparam int SCORE_W = 33;
  localparam int CFG_W   = 13;
  localparam int PIDX_W  = 12;

  localparam logic [WB-1:0] FRAME_MAX = {1'b1, {COORD_BITS{1'b0}}};

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_PATCHES_X    = 2'd2,
    REG_PATCHES_Y    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic        [11:0] pix_x;
    logic        [11:0] pix_y;
    logic        [31:0] tensor_xx;
    logic signed [31:0] tensor_xy;
    logic        [31:0] tensor_yy;
  } in_word_t;

  typedef struct packed {
    logic        [11:0] patch_index;
    logic        [11:0] key_x;
    logic        [11:0] key_y;
    logic        [31:0] key_xx;
    logic signed [31:0] key_xy;
    logic        [31:0] key_yy;
    logic               frame_done;
  } out_word_t;

  // One entry of the per-column store
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [11:0]        col;
    logic [11:0]        line;
    logic [31:0]        xx;
    logic [31:0]        xy;
    logic [31:0]        yy;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_LOAD,
    S_DIV,
    S_MULC,
    S_CMP
  } state_t;

endpackage

// ----- hdl/pks_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; instanced for the per-column store.
module pks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/pks_div.sv -----
// Restoring divider that finds which patch holds a coordinate, one quotient
// bit a cycle. Depends on pks_pkg.
module pks_div import pks_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVB-1:0]   dividend,
  input  logic [WB-1:0]    divisor,
  output logic [QBITS-1:0] quotient,
  output logic             done
);

  localparam int CNT_W = $clog2(QBITS + 1);

  logic [COORD_BITS-1:0] rem;
  logic [COORD_BITS-1:0] rem_next;
  logic [QBITS-1:0]      quo;
  logic [QBITS-1:0]      quo_next;
  logic [CNT_W-1:0]      cnt;
  logic [WB-1:0]         trial;
  logic [WB-1:0]         diff;
  logic                  fits;
  logic [QBITS:0]        shifted;

  // One restoring step: bring down the next dividend bit and try the divisor.
  // The quotient is known to fit QBITS bits, so the upper dividend bits
  // start out below the divisor.
  always_comb begin
    trial    = {rem, quo[QBITS-1]};
    diff     = trial - divisor;
    fits     = (trial >= divisor);
    rem_next = fits ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
    shifted  = {quo, fits};
    quo_next = shifted[QBITS-1:0];
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(QBITS);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[DVB-1:QBITS];
      quo <= dividend[QBITS-1:0];
    end else if (cnt != '0) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;
  assign done     = (cnt == '0);

endmodule

// ----- hdl/patch_keypoint_select_top.sv -----
// Top level of the patch keypoint selector: configuration registers,
// sequencer, column store and output register. Depends on pks_pkg, pks_div
// and pks_ram.
//
// Usage. Structure-tensor pixels enter on in_valid/in_ready/in_data in raster
// order; each word carries its column and line. For every patch the block
// keeps the pixel with the largest trace xx+yy (the earlier pixel wins a tie)
// and, when the patch's bottom-right pixel arrives, sends one word on
// out_valid/out_ready/out_data with the patch index, the winner and its
// tensor. Pixels outside the frame are dropped silently.
// Sequencing: a pixel is taken only while the sequencer is idle, so the next
// pixel waits until the last one is through; a pixel outside the frame leaves
// after the PREP state. For a pixel inside the frame most of the work is the
// patch search: a restoring divider working out one of six quotient bits a
// cycle for column and line, followed by a product stage and one
// read-modify-write of the column store, whose read is registered.
// The output register holds one word; the next pixel is taken while
// it waits, and only a second result stalls the sequencer until out_ready.
// Reset restores the default geometry (640 by 480, 8 by 8 patches) and
// empties the output register; the column store is not cleared, since each
// patch starts by overwriting its entry at its top-left pixel.
// The configuration port (cfg_we, cfg_index, cfg_data) writes one register
// per cycle and should be used only while the block is idle.
module patch_keypoint_select_top import pks_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  // Configuration registers
  logic [12:0] frame_width;
  logic [12:0] frame_height;
  logic [6:0]  patches_x;
  logic [6:0]  patches_y;

  // Effective geometry after clamping
  logic [WB-1:0] w_eff;
  logic [WB-1:0] h_eff;
  logic [PB-1:0] px_eff;
  logic [PB-1:0] py_eff;

  state_t state;
  state_t state_next;

  in_word_t item;
  logic     in_frame;

  logic [PRODB-1:0] xp;
  logic [PRODB-1:0] x1p;
  logic [PRODB-1:0] yp;
  logic [PRODB-1:0] y1p;
  logic [PRODB-1:0] cw0x;
  logic [PRODB-1:0] cw1x;
  logic [PRODB-1:0] cw0y;
  logic [PRODB-1:0] cw1y;
  logic [PRODB-1:0] pidx_full;
  logic [PIDX_W-1:0] pidx;
  logic             fdone;

  logic             div_start;
  logic [DVB-1:0]   dvd_x;
  logic [DVB-1:0]   dvd_y;
  logic [QBITS-1:0] cx;
  logic [QBITS-1:0] cy;
  logic             div_done_x;
  logic             div_done_y;

  entry_t             rd_entry;
  entry_t             wr_entry;
  logic               ram_we;
  logic [SCORE_W-1:0] score_new;
  logic               first_pix;
  logic               last_pix;
  logic               upd;
  logic               cmp_go;
  logic               out_load;
  out_word_t          res_word;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 13'd640;
      frame_height <= 13'd480;
      patches_x    <= 7'd8;
      patches_y    <= 7'd8;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[12:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[12:0];
        REG_PATCHES_X:    patches_x    <= cfg_data[6:0];
        REG_PATCHES_Y:    patches_y    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Clamp the geometry: zero acts as one, anything above the limit as the limit.
  always_comb begin
    int unsigned fw;
    int unsigned fh;
    int unsigned nx;
    int unsigned ny;
    fw = 32'(frame_width);
    fh = 32'(frame_height);
    nx = 32'(patches_x);
    ny = 32'(patches_y);
    w_eff  = (fw == 0) ? WB'(1) : ((fw > 32'(FRAME_MAX)) ? FRAME_MAX : WB'(fw));
    h_eff  = (fh == 0) ? WB'(1) : ((fh > 32'(FRAME_MAX)) ? FRAME_MAX : WB'(fh));
    px_eff = (nx == 0) ? PB'(1) :
             ((nx > MAX_PATCH_COLS) ? PB'(MAX_PATCH_COLS) : PB'(nx));
    py_eff = (ny == 0) ? PB'(1) :
             ((ny > PATCH_ROWS_MAX) ? PB'(PATCH_ROWS_MAX) : PB'(ny));
  end

  // The pixel counts only when it lies inside the frame.
  assign in_frame = (WB'(item.pix_x) < w_eff) && (WB'(item.pix_y) < h_eff);

  // Sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_PREP;
      S_PREP: state_next = in_frame ? S_LOAD : S_IDLE;
      S_LOAD: state_next = S_DIV;
      S_DIV:  if (div_done_x && div_done_y) state_next = S_MULC;
      S_MULC: state_next = S_CMP;
      S_CMP:  if (cmp_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    ram_we    = 1'b0;
    out_load  = 1'b0;
    case (state)
      S_IDLE: in_ready = 1'b1;
      S_LOAD: div_start = 1'b1;
      S_CMP: begin
        ram_we   = cmp_go && upd;
        out_load = cmp_go && last_pix;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the accepted word
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

  // Coordinate times patch count, for the patch search and the bound checks
  always_ff @(posedge clk) begin
    if (state == S_PREP) begin
      xp  <= PRODB'(item.pix_x) * PRODB'(px_eff);
      x1p <= (PRODB'(item.pix_x) + PRODB'(1)) * PRODB'(px_eff);
      yp  <= PRODB'(item.pix_y) * PRODB'(py_eff);
      y1p <= (PRODB'(item.pix_y) + PRODB'(1)) * PRODB'(py_eff);
    end
  end

  // Patch of a coordinate c is ((c+1)*p - 1) / size.
  always_comb begin
    logic [PRODB-1:0] nx;
    logic [PRODB-1:0] ny;
    nx    = x1p - PRODB'(1);
    ny    = y1p - PRODB'(1);
    dvd_x = nx[DVB-1:0];
    dvd_y = ny[DVB-1:0];
  end

  pks_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd_x),
    .divisor  (w_eff),
    .quotient (cx),
    .done     (div_done_x)
  );

  pks_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd_y),
    .divisor  (h_eff),
    .quotient (cy),
    .done     (div_done_y)
  );

  // Patch bounds scaled by the patch count, patch index and last-patch flag
  assign pidx_full = PRODB'(cy) * PRODB'(px_eff) + PRODB'(cx);

  always_ff @(posedge clk) begin
    if (state == S_MULC) begin
      cw0x  <= PRODB'(cx) * PRODB'(w_eff);
      cw1x  <= (PRODB'(cx) + PRODB'(1)) * PRODB'(w_eff);
      cw0y  <= PRODB'(cy) * PRODB'(h_eff);
      cw1y  <= (PRODB'(cy) + PRODB'(1)) * PRODB'(h_eff);
      pidx  <= pidx_full[PIDX_W-1:0];
      fdone <= (PB'(cx) == px_eff - PB'(1)) && (PB'(cy) == py_eff - PB'(1));
    end
  end

  // Column store: read in the product stage, written back in the compare stage
  pks_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_PATCH_COLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cx[COLQ-1:0]),
    .wdata (wr_entry),
    .raddr (cx[COLQ-1:0]),
    .rdata (rd_entry)
  );

  // Compare stage. A pixel starts its patch when floor(c*size/p) equals its
  // coordinate, that is c*size lies in [x*p, (x+1)*p); it ends the patch when
  // (c+1)*size lies in [(x+1)*p, (x+2)*p).
  always_comb begin
    first_pix = (xp <= cw0x) && (cw0x < x1p) && (yp <= cw0y) && (cw0y < y1p);
    last_pix  = (x1p <= cw1x) && (cw1x < x1p + PRODB'(px_eff)) &&
                (y1p <= cw1y) && (cw1y < y1p + PRODB'(py_eff));
    score_new = SCORE_W'(item.tensor_xx) + SCORE_W'(item.tensor_yy);
    upd       = first_pix || (score_new > rd_entry.score);
    cmp_go    = !last_pix || !out_valid || out_ready;

    wr_entry.score = score_new;
    wr_entry.col   = item.pix_x;
    wr_entry.line  = item.pix_y;
    wr_entry.xx    = item.tensor_xx;
    wr_entry.xy    = item.tensor_xy;
    wr_entry.yy    = item.tensor_yy;

    res_word.patch_index = pidx;
    res_word.frame_done  = fdone;
    if (upd) begin
      res_word.key_x  = item.pix_x;
      res_word.key_y  = item.pix_y;
      res_word.key_xx = item.tensor_xx;
      res_word.key_xy = item.tensor_xy;
      res_word.key_yy = item.tensor_yy;
    end else begin
      res_word.key_x  = rd_entry.col;
      res_word.key_y  = rd_entry.line;
      res_word.key_xx = rd_entry.xx;
      res_word.key_xy = rd_entry.xy;
      res_word.key_yy = rd_entry.yy;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= res_word;
    end
  end

  // The patch search never lands outside the patch grid.
  a_patch_in_grid: assert property (@(posedge clk) disable iff (rst)
    state == S_MULC |-> (PB'(cx) < px_eff) && (PB'(cy) < py_eff))
    else $error("patch search result outside the grid");

  // Both dividers have finished before their quotients are used.
  a_div_finished: assert property (@(posedge clk) disable iff (rst)
    (state == S_MULC || state == S_CMP) |-> div_done_x && div_done_y)
    else $error("patch quotient used while the divider is busy");

  // A new result never overwrites a word the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("result word overwritten");

  // An accepted word always starts the work sequence.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_PREP)
    else $error("accepted word not processed");

endmodule

// ----- tb/sv/patch_keypoint_select_top_tb.sv -----
// Self-checking testbench for patch_keypoint_select_top: directed rows, then
// random raster and sparse frames checked against an in-bench predictor.
// Depends on pks_pkg and the RTL in hdl/.
module patch_keypoint_select_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pks_pkg::*;

  typedef enum {ROW_CFG, ROW_PIX, ROW_NONE, ROW_KEY} row_kind_e;

  // One directed row: a register write (a = index, b = value) or a pixel
  // (a = column, b = line) with, for ROW_KEY, the result word typed in.
  typedef struct {
    row_kind_e   kind;
    int          a;
    int          b;
    logic [31:0] xx;
    logic [31:0] xy;
    logic [31:0] yy;
    out_word_t   key;
  } plan_row_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_word_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_word_t        out_data;
  logic             cfg_we    = 1'b0;
  logic [1:0]       cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0] cfg_data  = '0;

  // Register copies as written, and the geometry they act as after clamping.
  logic [12:0] reg_w  = 13'd640;
  logic [12:0] reg_h  = 13'd480;
  logic [6:0]  reg_px = 7'd8;
  logic [6:0]  reg_py = 7'd8;
  int geo_w = 640, geo_h = 480, geo_px = 8, geo_py = 8;

  // Running best pixel per patch column.
  logic [SCORE_W-1:0] lead_score [MAX_PATCH_COLS];
  logic [11:0]        lead_col   [MAX_PATCH_COLS];
  logic [11:0]        lead_line  [MAX_PATCH_COLS];
  logic [31:0]        lead_xx    [MAX_PATCH_COLS];
  logic signed [31:0] lead_xy    [MAX_PATCH_COLS];
  logic [31:0]        lead_yy    [MAX_PATCH_COLS];
  bit                 lead_known [MAX_PATCH_COLS];

  out_word_t pending_keys[$];
  out_word_t head_key;
  plan_row_t plan [0:29];
  int        mismatches = 0;
  int        pixels_in  = 0;
  bit        calm       = 1'b0;
  bit        paused     = 1'b0;

  patch_keypoint_select_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Geometry helpers: patch boundaries at floor(k*n/p), exact in integers.
  function automatic int clamp_to(int v, int hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  function automatic int bound(int k, int n, int p);
    return (k * n) / p;
  endfunction

  function automatic int segment(int c, int n, int p);
    int s;
    s = ((c + 1) * p - 1) / n;
    return (s >= p) ? p - 1 : s;
  endfunction

  // Updates the per-column best and returns 1 with the result word when the
  // pixel closes its patch.
  function automatic bit pick_keypoint(input in_word_t w, output out_word_t key);
    int x, y, cx, cy;
    logic [SCORE_W-1:0] score;
    bit opens;
    x = w.pix_x;
    y = w.pix_y;
    key = '0;
    if (x >= geo_w || y >= geo_h) return 1'b0;
    cx = segment(x, geo_w, geo_px);
    cy = segment(y, geo_h, geo_py);
    score = {1'b0, w.tensor_xx} + {1'b0, w.tensor_yy};
    opens = (x == bound(cx, geo_w, geo_px)) && (y == bound(cy, geo_h, geo_py));
    if (opens || score > lead_score[cx]) begin
      lead_score[cx] = score;
      lead_col[cx]   = w.pix_x;
      lead_line[cx]  = w.pix_y;
      lead_xx[cx]    = w.tensor_xx;
      lead_xy[cx]    = w.tensor_xy;
      lead_yy[cx]    = w.tensor_yy;
      lead_known[cx] = 1'b1;
    end
    if (x + 1 == bound(cx + 1, geo_w, geo_px) && y + 1 == bound(cy + 1, geo_h, geo_py)) begin
      key.patch_index = 12'(cy * geo_px + cx);
      key.key_x       = lead_col[cx];
      key.key_y       = lead_line[cx];
      key.key_xx      = lead_xx[cx];
      key.key_xy      = lead_xy[cx];
      key.key_yy      = lead_yy[cx];
      key.frame_done  = (cx == geo_px - 1) && (cy == geo_py - 1);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // A stray in-frame pixel is only sent if its column entry has been filled,
  // or if it opens its patch itself.
  function automatic bit readable(in_word_t w);
    int x, y, cx, cy;
    x = w.pix_x;
    y = w.pix_y;
    if (x >= geo_w || y >= geo_h) return 1'b1;
    cx = segment(x, geo_w, geo_px);
    cy = segment(y, geo_h, geo_py);
    return lead_known[cx] ||
           (x == bound(cx, geo_w, geo_px) && y == bound(cy, geo_h, geo_py));
  endfunction

  // Tensor entries lean towards zero, all ones and tiny values so that ties
  // and the top of the 33-bit trace turn up often.
  function automatic logic [31:0] tensor_value();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2, 3: return 32'($urandom_range(0, 7));
      4: return 32'h8000_0000 | 32'($urandom_range(0, 3));
      default: return $urandom();
    endcase
  endfunction

  function automatic in_word_t make_pixel(int x, int y);
    in_word_t w;
    int sel;
    sel = $urandom_range(0, 7);
    w.pix_x     = 12'(x);
    w.pix_y     = 12'(y);
    w.tensor_xx = tensor_value();
    w.tensor_xy = (sel == 0) ? 32'h8000_0000 : ((sel == 1) ? 32'h7FFF_FFFF : $urandom());
    w.tensor_yy = tensor_value();
    return w;
  endfunction

  // Register value at or beyond the ends of its range.
  function automatic int extreme_of(int top, int limit);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 1;
      2: return top;
      default: return $urandom_range(top + 1, limit);
    endcase
  endfunction

  // Register write; the block must be idle.
  task automatic write_reg(cfg_reg_t idx, int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  reg_w  = 13'(val);
      REG_FRAME_HEIGHT: reg_h  = 13'(val);
      REG_PATCHES_X:    reg_px = 7'(val);
      REG_PATCHES_Y:    reg_py = 7'(val);
      default: ;
    endcase
    geo_w  = clamp_to(reg_w, int'(FRAME_MAX));
    geo_h  = clamp_to(reg_h, int'(FRAME_MAX));
    geo_px = clamp_to(reg_px, MAX_PATCH_COLS);
    geo_py = clamp_to(reg_py, PATCH_ROWS_MAX);
  endtask

  // Drop valid, wait for every expected word, then let the pipeline empty of
  // pixels that give no result.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_geometry(int fw, int fh, int nx, int ny);
    settle();
    write_reg(REG_FRAME_WIDTH, fw);
    write_reg(REG_FRAME_HEIGHT, fh);
    write_reg(REG_PATCHES_X, nx);
    write_reg(REG_PATCHES_Y, ny);
  endtask

  // Present one pixel word, with random idle cycles ahead of it, and return
  // at the edge that accepts it.
  task automatic push_pixel(in_word_t w);
    calm = (pixels_in >= 600) && (pixels_in < 900);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    if (w.pix_x < geo_w && w.pix_y < geo_h) pixels_in++;
  endtask

  task automatic deliver(in_word_t w);
    out_word_t key;
    push_pixel(w);
    if (pick_keypoint(w, key)) pending_keys.push_back(key);
  endtask

  // Send a pixel of a well-formed sequence, now and then preceded by a pixel
  // outside the frame or a stray pixel inside it.
  task automatic feed(in_word_t w);
    in_word_t stray;
    if ($urandom_range(0, 99) < 8 && !(geo_w == int'(FRAME_MAX) && geo_h == int'(FRAME_MAX))) begin
      stray = make_pixel(0, 0);
      if (geo_h == int'(FRAME_MAX) || (geo_w < int'(FRAME_MAX) && $urandom_range(0, 1) == 1)) begin
        stray.pix_x = 12'($urandom_range(geo_w, 4095));
        stray.pix_y = 12'($urandom());
      end else begin
        stray.pix_y = 12'($urandom_range(geo_h, 4095));
        stray.pix_x = 12'($urandom());
      end
      deliver(stray);
    end
    if ($urandom_range(0, 99) < 3) begin
      stray = make_pixel($urandom_range(0, geo_w - 1), $urandom_range(0, geo_h - 1));
      if (readable(stray)) deliver(stray);
    end
    // Once in the run the sender holds off until the output has caught up.
    if (!paused && pixels_in >= 1100) begin
      settle();
      paused = 1'b1;
    end
    deliver(w);
  endtask

  // Full raster frame, sometimes cut short, with the odd repeated pixel.
  task automatic dense_frame();
    int cut;
    in_word_t w;
    cut = ($urandom_range(0, 99) < 15) ? $urandom_range(1, geo_w * geo_h) : geo_w * geo_h;
    for (int i = 0; i < cut; i++) begin
      w = make_pixel(i % geo_w, i / geo_w);
      feed(w);
      if ($urandom_range(0, 99) < 3) feed(w);
    end
  endtask

  // For large frames: a subset of patches, each opened at its top-left pixel,
  // given a few inner pixels and closed at its bottom-right pixel.
  task automatic sparse_frame();
    int x0, x1, y0, y1, n;
    n = geo_px * geo_py;
    for (int cy = 0; cy < geo_py; cy++) begin
      for (int cx = 0; cx < geo_px; cx++) begin
        if (!(cy == geo_py - 1 && cx == geo_px - 1) && $urandom_range(0, n - 1) >= 20)
          continue;
        x0 = bound(cx, geo_w, geo_px);
        x1 = bound(cx + 1, geo_w, geo_px);
        y0 = bound(cy, geo_h, geo_py);
        y1 = bound(cy + 1, geo_h, geo_py);
        if (x0 == x1 || y0 == y1) continue;
        feed(make_pixel(x0, y0));
        repeat ($urandom_range(0, 3))
          feed(make_pixel($urandom_range(x0, x1 - 1), $urandom_range(y0, y1 - 1)));
        if (x1 - 1 != x0 || y1 - 1 != y0) feed(make_pixel(x1 - 1, y1 - 1));
      end
    end
  endtask

  // Receiver: stalls at random outside the calm stretch.
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 28);
  end

  // Each accepted result word is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_keys.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: idx %0d at (%0d,%0d) xx %h xy %h yy %h done %0b",
                   out_data.patch_index, out_data.key_x, out_data.key_y, out_data.key_xx,
                   out_data.key_xy, out_data.key_yy, out_data.frame_done);
      end else begin
        head_key = pending_keys.pop_front();
        if (out_data.patch_index !== head_key.patch_index ||
            out_data.key_x !== head_key.key_x || out_data.key_y !== head_key.key_y ||
            out_data.key_xx !== head_key.key_xx || out_data.key_xy !== head_key.key_xy ||
            out_data.key_yy !== head_key.key_yy ||
            out_data.frame_done !== head_key.frame_done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word mismatch: expected idx %0d (%0d,%0d) %h %h %h %0b, got idx %0d (%0d,%0d) %h %h %h %0b",
                     head_key.patch_index, head_key.key_x, head_key.key_y, head_key.key_xx,
                     head_key.key_xy, head_key.key_yy, head_key.frame_done,
                     out_data.patch_index, out_data.key_x, out_data.key_y, out_data.key_xx,
                     out_data.key_xy, out_data.key_yy, out_data.frame_done);
        end
      end
    end
  end

  // Stimulus: reset, directed rows, random frames, then drain and report.
  initial begin
    int pick, fw, fh, nx, ny;
    bit busy;
    in_word_t pix;
    out_word_t key;
    plan = '{
      // Default 640 by 480 geometry, 8 by 8 patches: pixels off the frame,
      // the full trace beating zero, and a tie in the last patch.
      '{ROW_NONE, 640, 0, 32'h0, 32'h0, 32'h0, '0},
      '{ROW_NONE, 0, 480, 32'h0, 32'h0, 32'h0, '0},
      '{ROW_NONE, 4095, 4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0},
      '{ROW_NONE, 0, 0, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, '0},
      '{ROW_KEY, 79, 59, 32'h0, 32'h7FFF_FFFF, 32'h0,
        '{12'd0, 12'd0, 12'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0}},
      '{ROW_NONE, 560, 420, 32'h1, 32'h0, 32'h0, '0},
      '{ROW_KEY, 639, 479, 32'h0, 32'h1234_5678, 32'h1,
        '{12'd63, 12'd560, 12'd420, 32'h1, 32'h0, 32'h0, 1'b1}},
      // Zero sizes and counts act as one: a single-pixel frame.
      '{ROW_CFG, REG_FRAME_WIDTH, 0, 32'h0, 32'h0, 32'h0, '0},
      '{ROW_CFG, REG_FRAME_HEIGHT, 0, 32'h0, 32'h0, 32'h0, '0},
      '{ROW_CFG, REG_PATCHES_X, 0, 32'h0, 32'h0, 32'h0, '0},
      '{ROW_CFG, REG_PATCHES_Y, 0, 32'h0, 32'h0, 32'h0, '0},
      '{ROW_KEY, 0, 0, 32'h0, 32'h0, 32'h0,
        '{12'd0, 12'd0, 12'd0, 32'h0, 32'h0, 32'h0, 1'b1}},
      '{ROW_NONE, 1, 0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, '0},
      '{ROW_NONE, 0, 1, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, '0},
      // Oversized registers clamp to a 4096 square frame of 64 by 64 patches.
      '{ROW_CFG, REG_FRAME_WIDTH, 8191, 32'h0, 32'h0, 32'h0, '0},
      '{ROW_CFG, REG_FRAME_HEIGHT, 8191, 32'h0, 32'h0, 32'h0, '0},
      '{ROW_CFG, REG_PATCHES_X, 127, 32'h0, 32'h0, 32'h0, '0},
      '{ROW_CFG, REG_PATCHES_Y, 127, 32'h0, 32'h0, 32'h0, '0},
      '{ROW_NONE, 4032, 4032, 32'h0, 32'h7FFF_FFFF, 32'h0, '0},
      '{ROW_KEY, 4095, 4095, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0,
        '{12'd4095, 12'd4095, 12'd4095, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0, 1'b1}},
      // More patches than pixels: every pixel is a patch of its own.
      '{ROW_CFG, REG_FRAME_WIDTH, 3, 32'h0, 32'h0, 32'h0, '0},
      '{ROW_CFG, REG_FRAME_HEIGHT, 2, 32'h0, 32'h0, 32'h0, '0},
      '{ROW_CFG, REG_PATCHES_X, 5, 32'h0, 32'h0, 32'h0, '0},
      '{ROW_CFG, REG_PATCHES_Y, 4, 32'h0, 32'h0, 32'h0, '0},
      '{ROW_PIX, 0, 0, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0000_FFFF, '0},
      '{ROW_PIX, 1, 0, 32'h0000_0003, 32'hFFFF_FFFE, 32'h0000_0004, '0},
      '{ROW_PIX, 2, 0, 32'hFFFF_0000, 32'h0001_0000, 32'h0000_0000, '0},
      '{ROW_PIX, 0, 1, 32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, '0},
      '{ROW_PIX, 1, 1, 32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, '0},
      '{ROW_PIX, 2, 1, 32'hDEAD_BEEF, 32'hC0DE_CAFE, 32'h0BAD_F00D, '0}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows; register writes wait for the block to go idle.
    busy = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        if (busy) settle();
        busy = 1'b0;
        write_reg(cfg_reg_t'(plan[i].a), plan[i].b);
      end else begin
        pix.pix_x     = 12'(plan[i].a);
        pix.pix_y     = 12'(plan[i].b);
        pix.tensor_xx = plan[i].xx;
        pix.tensor_xy = plan[i].xy;
        pix.tensor_yy = plan[i].yy;
        push_pixel(pix);
        busy = 1'b1;
        if (pick_keypoint(pix, key) && plan[i].kind == ROW_PIX) pending_keys.push_back(key);
        if (plan[i].kind == ROW_KEY) pending_keys.push_back(plan[i].key);
      end
    end

    // Random part: mostly small raster frames, some sparse large frames and
    // some register values at or past the ends of their ranges.
    while (pixels_in < 1550) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        fw = $urandom_range(1, 10);
        fh = $urandom_range(1, 8);
        nx = $urandom_range(1, fw + 2);
        ny = $urandom_range(1, fh + 2);
        set_geometry(fw, fh, nx, ny);
        repeat ($urandom_range(1, 3)) dense_frame();
      end else if (pick < 85) begin
        set_geometry($urandom_range(16, 4096), $urandom_range(16, 4096),
                     $urandom_range(1, 8), $urandom_range(1, 8));
        sparse_frame();
      end else begin
        set_geometry(extreme_of(4096, 8191), extreme_of(4096, 8191),
                     extreme_of(64, 127), extreme_of(64, 127));
        sparse_frame();
      end
    end

    settle();
    if (mismatches == 0 && pending_keys.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
